// ----- hdl/deq_pkg.sv -----
// Shared types and constants for the double-ended queue.
// Holds command and error codes, payload structs and the cell control struct.
// No dependencies.
package deq_pkg;

    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int ERR_W   = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_STATUS     = 3'd5
    } t_deq_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } t_deq_err;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
    } t_deq_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic [ERR_W-1:0]         error_code;
        logic [COUNT_W-1:0]       entry_count;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
    } t_deq_out;

    // Operation broadcast to every cell of the chain
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic clear;
    } t_deq_ctrl;

endpackage

// ----- hdl/double_ended_queue.sv -----
// Top level of the bounded double-ended queue of 32-bit signed values.
// Instantiates a chain of deq_cell storage cells; uses deq_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one command
//   per transaction: push front, push back, pop front, pop back, clear or
//   status. Output channel (o_out_valid / i_out_ready / o_out_data) returns
//   exactly one result per command: popped value, error code, entry count,
//   and the front and back entries after the command.
//   Storage is a row of DEPTH cells; cell 0 holds the front entry. Front
//   commands shift the whole row by one place, back commands act on the
//   cell at the edge of the occupied run.
//   Flow: the command updates the cells at its acceptance edge; its result
//   is held pending, then loaded into the output register from the updated
//   row. One command is in flight at a time: o_in_ready stays low until the
//   pending result has moved into the output register.
//   Reset empties the queue (all cells unoccupied, count zero).
//   When the receiver stalls, the result waits in the output register; one
//   more command is still accepted and its result waits in a holding stage,
//   after which o_in_ready stays low until the output register drains.
//   Push on full is dropped and flagged; pop on empty is flagged and
//   changes nothing.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  deq_pkg::t_deq_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output deq_pkg::t_deq_out o_out_data
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    t_deq_ctrl                w_ctrl;
    logic [DEPTH-1:0]         w_cell_valid;
    logic signed [DATA_W-1:0] w_cell_data [DEPTH];
    logic signed [DATA_W-1:0] w_cell_tap  [DEPTH];
    logic signed [DATA_W-1:0] w_back;
    logic                     w_in_fire;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_out_load;
    logic signed [DATA_W-1:0] w_popped;
    t_deq_err                 w_err;

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_pend;
    logic signed [DATA_W-1:0] r_pend_popped;
    t_deq_err                 r_pend_err;
    logic                     r_out_valid;
    t_deq_out                 r_out_data;

    assign w_in_fire  = i_in_valid & o_in_ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_out_load = r_pend & (~r_out_valid | i_out_ready);

    // Command decode: operation for the cells, error, popped value, next count
    always_comb begin
        w_ctrl   = '0;
        w_err    = ERR_OK;
        w_popped = '0;
        n_count  = r_count;
        if (w_in_fire) begin
            case (i_in_data.command)
                CMD_PUSH_FRONT: begin
                    if (w_full) begin
                        w_err = ERR_FULL;
                    end else begin
                        w_ctrl.push_front = 1'b1;
                        n_count           = r_count + 1'b1;
                    end
                end
                CMD_PUSH_BACK: begin
                    if (w_full) begin
                        w_err = ERR_FULL;
                    end else begin
                        w_ctrl.push_back = 1'b1;
                        n_count          = r_count + 1'b1;
                    end
                end
                CMD_POP_FRONT: begin
                    if (w_empty) begin
                        w_err = ERR_EMPTY;
                    end else begin
                        w_ctrl.pop_front = 1'b1;
                        w_popped         = w_cell_data[0];
                        n_count          = r_count - 1'b1;
                    end
                end
                CMD_POP_BACK: begin
                    if (w_empty) begin
                        w_err = ERR_EMPTY;
                    end else begin
                        w_ctrl.pop_back = 1'b1;
                        w_popped        = w_back;
                        n_count         = r_count - 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    w_ctrl.clear = 1'b1;
                    n_count      = '0;
                end
                default: begin
                    // status and unused codes change nothing
                end
            endcase
        end
    end

    // Chain of storage cells; cell 0 sees the pushed value as an occupied left neighbor
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left_data;
        logic                     w_left_valid;
        logic signed [DATA_W-1:0] w_right_data;
        logic                     w_right_valid;

        if (g == 0) begin : g_head
            assign w_left_data  = i_in_data.value;
            assign w_left_valid = 1'b1;
        end else begin : g_body
            assign w_left_data  = w_cell_data[g-1];
            assign w_left_valid = w_cell_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_data  = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_data  = w_cell_data[g+1];
            assign w_right_valid = w_cell_valid[g+1];
        end

        deq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_push_value  (i_in_data.value),
            .i_left_data   (w_left_data),
            .i_left_valid  (w_left_valid),
            .i_right_data  (w_right_data),
            .i_right_valid (w_right_valid),
            .o_data        (w_cell_data[g]),
            .o_valid       (w_cell_valid[g]),
            .o_back_tap    (w_cell_tap[g])
        );
    end

    // Back entry: only the last occupied cell drives a nonzero tap
    always_comb begin
        w_back = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_back = w_back | w_cell_tap[k];
        end
    end

    // Entry count and pending-result control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_in_fire) begin
                r_pend <= 1'b1;
            end else if (w_out_load) begin
                r_pend <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pending result fields captured at acceptance
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_pend_popped <= w_popped;
            r_pend_err    <= w_err;
        end
    end

    // Output register, filled from the updated cell row
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data.popped_value <= r_pend_popped;
            r_out_data.error_code   <= r_pend_err;
            r_out_data.entry_count  <= COUNT_W'(r_count);
            r_out_data.front_value  <= w_cell_valid[0] ? w_cell_data[0] : '0;
            r_out_data.back_value   <= w_back;
        end
    end

    assign o_in_ready  = ~r_pend;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Count tracks the number of occupied cells
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(w_cell_valid)))
        else $error("entry count differs from occupied cells");

    // Occupied cells form one run starting at cell 0
    a_valid_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cell_valid & (w_cell_valid + 1'b1)) == '0)
        else $error("occupied cells are not contiguous from the front");

    // An accepted command always leaves a pending result
    a_accept_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_pend)
        else $error("accepted command left no pending result");

    // A failed command never reports a popped value
    a_err_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.error_code != ERR_OK) |-> r_out_data.popped_value == '0)
        else $error("error result carries a popped value");

endmodule

// ----- hdl/deq_cell.sv -----
// One storage cell of the queue chain: a data word and an occupied flag.
// Shifts with its neighbors on front operations, fills or empties at the back edge.
// Depends on deq_pkg.
module deq_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  deq_pkg::t_deq_ctrl                i_ctrl,
    input  logic signed [deq_pkg::DATA_W-1:0] i_push_value,
    input  logic signed [deq_pkg::DATA_W-1:0] i_left_data,
    input  logic                              i_left_valid,
    input  logic signed [deq_pkg::DATA_W-1:0] i_right_data,
    input  logic                              i_right_valid,
    output logic signed [deq_pkg::DATA_W-1:0] o_data,
    output logic                              o_valid,
    output logic signed [deq_pkg::DATA_W-1:0] o_back_tap
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     r_valid;
    logic                     n_valid;
    logic                     w_is_back;

    // This cell is the back entry when it is occupied and its right neighbor is not
    assign w_is_back = r_valid & ~i_right_valid;

    // Next contents from the broadcast operation and the neighbors
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctrl.push_front) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_ctrl.pop_front) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_ctrl.push_back && !r_valid && i_left_valid) begin
            n_data  = i_push_value;
            n_valid = 1'b1;
        end else if (i_ctrl.pop_back && w_is_back) begin
            n_valid = 1'b0;
        end
    end

    // Occupied flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Data word, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    assign o_valid    = r_valid;
    assign o_back_tap = w_is_back ? r_data : '0;

endmodule

// ----- verif/deq_checker.sv -----
// Scoreboard for the double-ended queue: watches both channels, predicts every result
// from its own ring-buffer copy of the queue and compares each returned transaction.
// Depends on deq_pkg.
module deq_checker #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  deq_pkg::t_deq_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  deq_pkg::t_deq_out i_out_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_full_drops,
    output int                o_empty_pops
);
    import deq_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Predicted queue contents: ring of slots, slot of the front entry, entries held
    logic signed [DATA_W-1:0] ring [DEPTH];
    int head_slot;
    int held;

    t_deq_out awaited_results [$];
    int fails;
    int checked;
    int full_drops;
    int empty_pops;

    // Apply one command to the predicted queue and return the result it should give
    function automatic t_deq_out model_command(input t_deq_in item);
        t_deq_out res;
        res = '0;
        res.error_code = ERR_OK;
        case (item.command)
            CMD_PUSH_FRONT: begin
                if (held >= DEPTH) begin
                    res.error_code = ERR_FULL;
                end else begin
                    head_slot = (head_slot + DEPTH - 1) % DEPTH;
                    ring[head_slot] = item.value;
                    held++;
                end
            end
            CMD_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    res.error_code = ERR_FULL;
                end else begin
                    ring[(head_slot + held) % DEPTH] = item.value;
                    held++;
                end
            end
            CMD_POP_FRONT: begin
                if (held == 0) begin
                    res.error_code = ERR_EMPTY;
                end else begin
                    res.popped_value = ring[head_slot];
                    head_slot = (head_slot + 1) % DEPTH;
                    held--;
                end
            end
            CMD_POP_BACK: begin
                if (held == 0) begin
                    res.error_code = ERR_EMPTY;
                end else begin
                    res.popped_value = ring[(head_slot + held - 1) % DEPTH];
                    held--;
                end
            end
            CMD_CLEAR: begin
                held = 0;
                head_slot = 0;
            end
            default: ; // status and the spare codes leave the queue alone
        endcase
        res.entry_count = COUNT_W'(held);
        if (held != 0) begin
            res.front_value = ring[head_slot];
            res.back_value  = ring[(head_slot + held - 1) % DEPTH];
        end
        return res;
    endfunction

    task automatic flag(input string what, input logic [DATA_W-1:0] want_v,
                        input logic [DATA_W-1:0] got_v);
        fails++;
        if (fails <= REPORT_LIMIT)
            $display("result %0d, %s: expected %h, got %h", checked, what, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : watch
        t_deq_out want;
        t_deq_out got;
        if (!i_rst_n) begin
            held = 0;
            head_slot = 0;
            awaited_results.delete();
        end else begin
            // Command transaction: predict its result
            if (i_in_valid && i_in_ready) begin
                want = model_command(i_in_data);
                if (want.error_code == ERR_FULL)
                    full_drops++;
                if (want.error_code == ERR_EMPTY)
                    empty_pops++;
                awaited_results.push_back(want);
            end
            // Result transaction: compare against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (awaited_results.size() == 0) begin
                    flag("result with no command outstanding", '0, got.popped_value);
                end else begin
                    want = awaited_results.pop_front();
                    checked++;
                    if (got.popped_value !== want.popped_value)
                        flag("popped_value", want.popped_value, got.popped_value);
                    if (got.error_code !== want.error_code)
                        flag("error_code", DATA_W'(want.error_code),
                             DATA_W'(got.error_code));
                    if (got.entry_count !== want.entry_count)
                        flag("entry_count", DATA_W'(want.entry_count),
                             DATA_W'(got.entry_count));
                    if (got.front_value !== want.front_value)
                        flag("front_value", want.front_value, got.front_value);
                    if (got.back_value !== want.back_value)
                        flag("back_value", want.back_value, got.back_value);
                end
            end
        end
        // Registered so the stimulus side reads them without racing this block
        o_fail_count <= fails;
        o_pending    <= awaited_results.size();
        o_checked    <= checked;
        o_full_drops <= full_drops;
        o_empty_pops <= empty_pops;
    end

endmodule

// ----- verif/tb_double_ended_queue.sv -----
// Testbench top for double_ended_queue: directed corner cases, then biased random
// command streams with bursty sender and stalling receiver; deq_checker does the scoring.
// Depends on deq_pkg, double_ended_queue and deq_checker.
module tb_double_ended_queue;
    import deq_pkg::*;

    localparam int DEPTH         = 16;
    localparam int RANDOM_ITEMS  = 525;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 12;

    // Codes outside the defined set; the queue treats them as status
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} t_stream_mode;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_deq_in  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_deq_out out_data;

    int fail_count;
    int pending;
    int checked;
    int full_drops;
    int empty_pops;

    int sent       = 0;
    int burst_left = 0;
    int stall_left = 0;
    int rx_cycle   = 0;

    always #2 clk = ~clk;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    deq_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_full_drops(full_drops),
        .o_empty_pops(empty_pops)
    );

    // Receiver: a recurring window without stalls, random stalls elsewhere
    always @(posedge clk) begin
        rx_cycle++;
        if (rx_cycle % 512 < 96) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 8);
        end
    end

    function automatic t_deq_in make_cmd(input logic [CMD_W-1:0] code,
                                         input logic signed [DATA_W-1:0] val);
        t_deq_in item;
        item.command = code;
        item.value   = val;
        return item;
    endfunction

    // Mostly full-range random values, with the extremes mixed in
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Fill streams favor pushes, drain streams favor pops, mix covers every code
    function automatic t_deq_in random_cmd(input t_stream_mode mode);
        int roll;
        logic [CMD_W-1:0] code;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                code = roll < 40 ? CMD_PUSH_FRONT : roll < 80 ? CMD_PUSH_BACK :
                       roll < 88 ? CMD_POP_FRONT  : roll < 96 ? CMD_POP_BACK  : CMD_STATUS;
            MODE_DRAIN:
                code = roll < 40 ? CMD_POP_FRONT  : roll < 80 ? CMD_POP_BACK  :
                       roll < 88 ? CMD_PUSH_FRONT : roll < 96 ? CMD_PUSH_BACK : CMD_STATUS;
            default:
                code = roll < 18 ? CMD_PUSH_FRONT : roll < 36 ? CMD_PUSH_BACK :
                       roll < 54 ? CMD_POP_FRONT  : roll < 72 ? CMD_POP_BACK  :
                       roll < 78 ? CMD_CLEAR      : roll < 86 ? CMD_STATUS    :
                       roll < 93 ? CMD_SPARE_A    : CMD_SPARE_B;
        endcase
        return make_cmd(code, pick_value());
    endfunction

    // One command transaction; opens a new burst after a short gap when the last one ran out
    task automatic send_cmd(input t_deq_in item);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        sent++;
        do @(posedge clk); while (!in_ready);
    endtask

    initial begin : stimulus
        t_stream_mode mode;
        int seg_left;
        int n;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Pops on empty, extreme values through both ends
        send_cmd(make_cmd(CMD_POP_FRONT, VAL_MAX));
        send_cmd(make_cmd(CMD_POP_BACK, VAL_MIN));
        send_cmd(make_cmd(CMD_PUSH_BACK, VAL_MAX));
        send_cmd(make_cmd(CMD_PUSH_FRONT, VAL_MIN));
        send_cmd(make_cmd(CMD_POP_BACK, '0));
        send_cmd(make_cmd(CMD_POP_FRONT, '0));

        // Fill from both ends, then push into a full queue and clear it
        for (n = 0; n < DEPTH; n++)
            send_cmd(make_cmd(n[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                              (n == 0) ? -32'sd1 : (n == 1) ? '0 : $urandom));
        send_cmd(make_cmd(CMD_PUSH_FRONT, VAL_MAX));
        send_cmd(make_cmd(CMD_PUSH_BACK, VAL_MIN));
        send_cmd(make_cmd(CMD_CLEAR, VAL_MAX));

        // Random streams in segments of one flavor each
        seg_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                mode = t_stream_mode'($urandom_range(0, 2));
                seg_left = $urandom_range(8, 40);
            end
            seg_left--;
            send_cmd(random_cmd(mode));
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Drove %0d commands (directed corners, then fill/drain/mixed streams), %0d results compared.",
                 sent, checked);
        $display("Refused pushes on a full queue: %0d, pops on an empty queue: %0d.",
                 full_drops, empty_pops);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding.", cycles, pending);
        $display("FAILURE");
        $finish;
    end

endmodule
